// ===== rtl/prfc_pkg.sv =====
// Shared types, codes and pixel conversion functions for the pixel region format converter.
`default_nettype none

package prfc_pkg;

    localparam int unsigned CNT_W    = 12;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned OFS_W    = 28;
    localparam int unsigned IDX_W    = 24;
    localparam int unsigned CFG_IW   = 3;
    localparam int unsigned CFG_DW   = 32;

    typedef enum logic [CFG_IW-1:0] {
        REG_FORMAT     = 3'd0,
        REG_SRC_STRIDE = 3'd1,
        REG_DST_STRIDE = 3'd2,
        REG_X          = 3'd3,
        REG_Y          = 3'd4,
        REG_WIDTH      = 3'd5,
        REG_HEIGHT     = 3'd6
    } t_reg_index;

    typedef enum logic [1:0] {
        FMT_RGB565   = 2'd0,
        FMT_ABGR1555 = 2'd1,
        FMT_RGBA8888 = 2'd2,
        FMT_BGRA8888 = 2'd3
    } t_format;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef struct packed {
        t_format          fmt;
        logic [DIM_W-1:0] src_stride;
        logic [DIM_W-1:0] dst_stride;
        logic [CNT_W-1:0] x;
        logic [CNT_W-1:0] y;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] bgra;
        logic [DIM_W-1:0] ypos;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             done;
        t_status          status;
    } t_entry;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [PIX_W-1:0] to_bgra(input t_format fmt,
                                                 input logic [PIX_W-1:0] px);
        logic [PIX_W-1:0] res;
        res = px;
        unique case (fmt)
            FMT_RGB565:   res = {8'hFF, widen5(px[15:11]), widen6(px[10:5]), widen5(px[4:0])};
            FMT_ABGR1555: res = {8'hFF, widen5(px[4:0]), widen5(px[9:5]), widen5(px[14:10])};
            FMT_RGBA8888: res = {px[31:24], px[7:0], px[15:8], px[23:16]};
            FMT_BGRA8888: res = px;
            default:      res = px;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pixel_region_format_converter.sv =====
// Top level of the pixel region format converter: configuration registers and wiring.
`default_nettype none

// Converts one source pixel word per clock while the queue has room to BGRA8888 and tags
// it with its source byte offset, destination pixel index, end-of-region flag and status.
// Sustained rate is one word per clock while the output accepts; a word is written into
// the queue, then after the offset multiply-add of the back end into its output register.
// The queue of QUEUE_DEPTH words lets input keep flowing while the output stalls.
// Configuration is taken on any cycle and must only change while idle.
module pixel_region_format_converter #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [prfc_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [prfc_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [prfc_pkg::PIX_W-1:0]  i_source_pixel,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [prfc_pkg::PIX_W-1:0]       o_bgra_pixel,
    output logic [prfc_pkg::OFS_W-1:0]       o_source_offset,
    output logic [prfc_pkg::IDX_W-1:0]       o_dest_index,
    output logic                             o_region_done,
    output logic [1:0]                       o_status
);
    import prfc_pkg::*;

    t_cfg   r_cfg;
    t_entry front_entry;
    t_entry queue_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_FORMAT:     r_cfg.fmt        <= t_format'(i_cfg_data[1:0]);
                REG_SRC_STRIDE: r_cfg.src_stride <= i_cfg_data[DIM_W-1:0];
                REG_DST_STRIDE: r_cfg.dst_stride <= i_cfg_data[DIM_W-1:0];
                REG_X:          r_cfg.x          <= i_cfg_data[CNT_W-1:0];
                REG_Y:          r_cfg.y          <= i_cfg_data[CNT_W-1:0];
                REG_WIDTH:      r_cfg.width      <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT:     r_cfg.height     <= i_cfg_data[DIM_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    prfc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_source_pixel (i_source_pixel),
        .i_full         (q_full),
        .o_push         (push),
        .o_entry        (front_entry)
    );

    prfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    prfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (q_empty),
        .i_entry         (queue_entry),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_bgra_pixel    (o_bgra_pixel),
        .o_source_offset (o_source_offset),
        .o_dest_index    (o_dest_index),
        .o_region_done   (o_region_done),
        .o_status        (o_status)
    );

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_bgra_pixel == '0 && o_source_offset == '0 && o_dest_index == '0
             && !o_region_done))
        else $error("non-ok word carries nonzero fields");

    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region_done) |-> (o_status == ST_OK))
        else $error("region end flagged on a non-ok word");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_out_valid)
        else $error("popped word did not reach the output");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("push into a full queue");

endmodule

`default_nettype wire

// ===== rtl/prfc_front.sv =====
// Front end: accepts pixels, checks the region, converts the pixel and tracks column and row.
`default_nettype none

module prfc_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire prfc_pkg::t_cfg          i_cfg,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [prfc_pkg::PIX_W-1:0] i_source_pixel,
    input  wire logic                    i_full,
    output logic                         o_push,
    output prfc_pkg::t_entry             o_entry
);
    import prfc_pkg::*;

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             empty_region;
    logic             invalid_region;
    logic [DIM_W:0]   right_edge;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             row_end;
    logic             last;
    t_status          status;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        empty_region   = (i_cfg.width == '0) || (i_cfg.height == '0);
        right_edge     = (DIM_W+1)'(i_cfg.x) + (DIM_W+1)'(i_cfg.width);
        invalid_region = (i_cfg.dst_stride < i_cfg.width)
                      || (right_edge > (DIM_W+1)'(i_cfg.src_stride));
        if (empty_region) begin
            status = ST_EMPTY;
        end else if (invalid_region) begin
            status = ST_INVALID;
        end else begin
            status = ST_OK;
        end

        col_inc = DIM_W'(r_col) + DIM_W'(1);
        row_inc = DIM_W'(r_row) + DIM_W'(1);
        row_end = col_inc >= i_cfg.width;
        last    = row_end && (row_inc >= i_cfg.height);

        n_col = r_col;
        n_row = r_row;
        if (o_push && status == ST_OK) begin
            if (last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = row_inc[CNT_W-1:0];
            end else begin
                n_col = col_inc[CNT_W-1:0];
            end
        end

        o_entry.status = status;
        o_entry.bgra   = (status == ST_OK) ? to_bgra(i_cfg.fmt, i_source_pixel) : '0;
        o_entry.ypos   = DIM_W'(i_cfg.y) + DIM_W'(r_row);
        o_entry.col    = r_col;
        o_entry.row    = r_row;
        o_entry.done   = (status == ST_OK) && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prfc_queue.sv =====
// Short first-in first-out queue of classified words between front and back end.
`default_nettype none

module prfc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire prfc_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output prfc_pkg::t_entry      o_entry,
    output logic                  o_full,
    output logic                  o_empty
);
    import prfc_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prfc_back.sv =====
// Back end: computes source offset and destination index and holds the output word.
`default_nettype none

module prfc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire prfc_pkg::t_cfg             i_cfg,
    input  wire logic                       i_empty,
    input  wire prfc_pkg::t_entry           i_entry,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [prfc_pkg::PIX_W-1:0]      o_bgra_pixel,
    output logic [prfc_pkg::OFS_W-1:0]      o_source_offset,
    output logic [prfc_pkg::IDX_W-1:0]      o_dest_index,
    output logic                            o_region_done,
    output logic [1:0]                      o_status
);
    import prfc_pkg::*;

    localparam int unsigned SP_W = 2 * DIM_W;
    localparam int unsigned SS_W = SP_W + 1;
    localparam int unsigned DP_W = CNT_W + DIM_W;

    logic             r_valid;
    logic [PIX_W-1:0] r_bgra;
    logic [OFS_W-1:0] r_sofs;
    logic [IDX_W-1:0] r_didx;
    logic             r_done;
    t_status          r_status;

    logic [SP_W-1:0]  src_prod;
    logic [SS_W-1:0]  src_sum;
    logic [DP_W-1:0]  dst_prod;
    logic [OFS_W-1:0] sofs;
    logic [IDX_W-1:0] didx;
    logic             half_word;
    logic             ok;

    assign o_pop = !i_empty && (!r_valid || i_out_ready);

    always_comb begin
        ok        = (i_entry.status == ST_OK);
        half_word = (i_cfg.fmt == FMT_RGB565) || (i_cfg.fmt == FMT_ABGR1555);
        src_prod  = i_entry.ypos * i_cfg.src_stride;
        src_sum   = SS_W'(src_prod) + SS_W'(i_cfg.x) + SS_W'(i_entry.col);
        dst_prod  = i_entry.row * i_cfg.dst_stride;
        if (!ok) begin
            sofs = '0;
        end else if (half_word) begin
            sofs = {src_sum[OFS_W-2:0], 1'b0};
        end else begin
            sofs = {src_sum[OFS_W-3:0], 2'b00};
        end
        didx = ok ? dst_prod[IDX_W-1:0] + IDX_W'(i_entry.col) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bgra   <= i_entry.bgra;
            r_sofs   <= sofs;
            r_didx   <= didx;
            r_done   <= i_entry.done;
            r_status <= i_entry.status;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_bgra_pixel    = r_bgra;
    assign o_source_offset = r_sofs;
    assign o_dest_index    = r_didx;
    assign o_region_done   = r_done;
    assign o_status        = r_status;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for pixel_region_format_converter with a scoreboard-based predictor.
module testbench;
    import prfc_pkg::*;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned RANDOM_WORDS = 860;

    typedef struct packed {
        logic [PIX_W-1:0] bgra;
        logic [OFS_W-1:0] offset;
        logic [IDX_W-1:0] index;
        logic             done;
        t_status          status;
    } t_pixel_result;

    typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SLOW, DRAIN_PATTERN} t_drain_mode;

    class conversion_scoreboard;
        t_format          fmt;
        logic [DIM_W-1:0] src_stride;
        logic [DIM_W-1:0] dst_stride;
        logic [CNT_W-1:0] left_col;
        logic [CNT_W-1:0] top_row;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        t_pixel_result    awaited_words[$];
        int               errors;
        int               checked;

        function new();
            fmt = FMT_RGB565;
            src_stride = '0;
            dst_stride = '0;
            left_col = '0;
            top_row = '0;
            width = '0;
            height = '0;
            col = '0;
            row = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_register(t_reg_index idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_FORMAT:     fmt = t_format'(data[1:0]);
                REG_SRC_STRIDE: src_stride = data[DIM_W-1:0];
                REG_DST_STRIDE: dst_stride = data[DIM_W-1:0];
                REG_X:          left_col = data[CNT_W-1:0];
                REG_Y:          top_row = data[CNT_W-1:0];
                REG_WIDTH:      width = data[DIM_W-1:0];
                REG_HEIGHT:     height = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] expand_pixel(logic [PIX_W-1:0] px);
            logic [4:0] r5;
            logic [4:0] g5;
            logic [4:0] b5;
            logic [5:0] g6;
            case (fmt)
                FMT_RGB565: begin
                    r5 = px[15:11];
                    g6 = px[10:5];
                    b5 = px[4:0];
                    return {8'hFF, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
                end
                FMT_ABGR1555: begin
                    b5 = px[14:10];
                    g5 = px[9:5];
                    r5 = px[4:0];
                    return {8'hFF, r5, r5[4:2], g5, g5[4:2], b5, b5[4:2]};
                end
                FMT_RGBA8888: return {px[31:24], px[7:0], px[15:8], px[23:16]};
                default:      return px;
            endcase
        endfunction

        function void note_source_word(logic [PIX_W-1:0] px);
            t_pixel_result   want;
            longint unsigned bpp;
            longint unsigned ofs;
            longint unsigned idx;
            bit              row_end;
            bit              last;
            want = '0;
            if (width == 0 || height == 0) begin
                want.status = ST_EMPTY;
            end else if (dst_stride < width ||
                         32'(left_col) + 32'(width) > 32'(src_stride)) begin
                want.status = ST_INVALID;
            end else begin
                bpp = (fmt == FMT_RGB565 || fmt == FMT_ABGR1555) ? 2 : 4;
                ofs = ((64'(top_row) + 64'(row)) * 64'(src_stride) + 64'(left_col) +
                       64'(col)) * bpp;
                idx = 64'(row) * 64'(dst_stride) + 64'(col);
                row_end = 32'(col) + 1 >= 32'(width);
                last = row_end && (32'(row) + 1 >= 32'(height));
                want.bgra = expand_pixel(px);
                want.offset = ofs[OFS_W-1:0];
                want.index = idx[IDX_W-1:0];
                want.done = last;
                want.status = ST_OK;
                if (last) begin
                    col = '0;
                    row = '0;
                end else if (row_end) begin
                    col = '0;
                    row = row + 1'b1;
                end else begin
                    col = col + 1'b1;
                end
            end
            awaited_words.push_back(want);
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        task flag_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
            errors++;
            if (errors <= 40)
                $display("mismatch on %s at word %0d: got %0h, want %0h",
                         what, checked, got, want);
        endtask

        task check_converted_word(t_pixel_result got);
            t_pixel_result want;
            if (awaited_words.size() == 0) begin
                flag_mismatch("unexpected word", got.bgra, '0);
            end else begin
                want = awaited_words.pop_front();
                if (got.bgra !== want.bgra)
                    flag_mismatch("bgra_pixel", got.bgra, want.bgra);
                if (got.offset !== want.offset)
                    flag_mismatch("source_offset", got.offset, want.offset);
                if (got.index !== want.index)
                    flag_mismatch("dest_index", got.index, want.index);
                if (got.done !== want.done)
                    flag_mismatch("region_done", got.done, want.done);
                if (got.status !== want.status)
                    flag_mismatch("status", got.status, want.status);
            end
            checked++;
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    t_reg_index       cfg_index = REG_FORMAT;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic             pix_valid = 1'b0;
    logic             pix_ready;
    logic [PIX_W-1:0] pix_data = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    logic [PIX_W-1:0] res_bgra;
    logic [OFS_W-1:0] res_offset;
    logic [IDX_W-1:0] res_index;
    logic             res_done;
    logic [1:0]       res_status;

    bit               hold_request = 1'b0;
    int unsigned      hold_left = 0;
    t_drain_mode      drain_mode = DRAIN_FREE;
    int unsigned      mode_left = 0;
    int unsigned      tick = 0;
    int unsigned      idle_cycles = 0;

    conversion_scoreboard sb = new();

    pixel_region_format_converter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (pix_valid),
        .o_in_ready      (pix_ready),
        .i_source_pixel  (pix_data),
        .o_out_valid     (res_valid),
        .i_out_ready     (res_ready),
        .o_bgra_pixel    (res_bgra),
        .o_source_offset (res_offset),
        .o_dest_index    (res_index),
        .o_region_done   (res_done),
        .o_status        (res_status)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 100;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                drain_mode = t_drain_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            tick++;
            case (drain_mode)
                DRAIN_FREE:  res_ready = 1'b1;
                DRAIN_COIN:  res_ready = $urandom_range(0, 1);
                DRAIN_SLOW:  res_ready = ($urandom_range(0, 3) == 0);
                default:     res_ready = (tick % 3 != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            sb.check_converted_word({res_bgra, res_offset, res_index, res_done,
                                     t_status'(res_status)});
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((pix_valid && pix_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(t_reg_index idx, logic [CFG_DW-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, value);
        @(negedge clk);
    endtask

    task automatic program_region(t_format f, int unsigned ss, int unsigned ds,
                                  int unsigned px, int unsigned py,
                                  int unsigned w, int unsigned h);
        t_reg_index        order[7];
        int unsigned       vals[7];
        int unsigned       widths[7];
        logic [CFG_DW-1:0] junk;
        order = '{REG_FORMAT, REG_SRC_STRIDE, REG_DST_STRIDE, REG_X, REG_Y,
                  REG_WIDTH, REG_HEIGHT};
        vals = '{f, ss, ds, px, py, w, h};
        widths = '{$bits(t_format), DIM_W, DIM_W, CNT_W, CNT_W, DIM_W, DIM_W};
        while (sb.pending() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        for (int k = 0; k < 7; k++) begin
            junk = ($urandom_range(0, 3) == 0) ? ($urandom << widths[k]) : '0;
            write_reg(order[k], vals[k] | junk);
        end
        cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px);
        pix_valid = 1'b1;
        pix_data = px;
        do @(posedge clk); while (!pix_ready);
        sb.note_source_word(px);
        @(negedge clk);
    endtask

    task automatic send_words(input logic [PIX_W-1:0] words[$]);
        foreach (words[k]) send_pixel(words[k]);
        pix_valid = 1'b0;
    endtask

    task automatic stream_pixels(int unsigned count, bit gapless);
        int unsigned left_in_burst;
        int unsigned gap;
        left_in_burst = 0;
        for (int unsigned n = 0; n < count; n++) begin
            if (left_in_burst == 0)
                left_in_burst = $urandom_range(1, 24);
            send_pixel(pick_pixel());
            left_in_burst--;
            if (left_in_burst == 0 && !gapless) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    pix_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
        pix_valid = 1'b0;
    endtask

    task automatic random_phase(output int unsigned sent);
        t_format     f;
        int unsigned kind;
        int unsigned w;
        int unsigned h;
        int unsigned px;
        int unsigned py;
        int unsigned ss;
        int unsigned ds;
        int unsigned n;
        f = t_format'($urandom_range(0, 3));
        kind = $urandom_range(0, 19);
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        px = $urandom_range(0, 4095);
        py = $urandom_range(0, 4095);
        if (kind < 3) begin
            px = $urandom_range(0, 1) ? 4095 : 0;
            py = $urandom_range(0, 1) ? 4095 : 0;
            w = $urandom_range(0, 1) ? 4096 : 1;
            h = $urandom_range(0, 1) ? 4096 : $urandom_range(1, 3);
        end
        ss = px + w + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8191 - px - w));
        ds = w + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8191 - w));
        if (kind == 3) begin
            if ($urandom_range(0, 1))
                w = 0;
            else
                h = 0;
        end else if (kind == 4) begin
            if ($urandom_range(0, 1))
                ds = w - 1;
            else
                ss = px + w - 1;
        end
        program_region(f, ss, ds, px, py, w, h);
        n = $urandom_range(1, 40);
        if ($urandom_range(0, 5) == 0) begin
            stream_pixels(n / 2 + 1, 1'b0);
            while (sb.pending() != 0) @(negedge clk);
            stream_pixels(n - n / 2, 1'b0);
            sent = n + 1;
        end else begin
            stream_pixels(n, $urandom_range(0, 5) == 0);
            sent = n;
        end
    endtask

    initial begin
        logic [PIX_W-1:0] words[$];
        int unsigned      random_words;
        int unsigned      sent;
        random_words = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        words = '{32'hFFFF_FFFF};
        send_words(words);

        program_region(FMT_RGB565, 8, 4, 1, 2, 3, 2);
        words = '{32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_F800, 32'h0000_07E0,
                  32'h0000_001F, 32'h5A5A_A5A5};
        send_words(words);
        program_region(FMT_ABGR1555, 8, 4, 1, 2, 3, 2);
        words = '{32'h0000_7C00, 32'h0000_03E0, 32'hFFFF_801F};
        send_words(words);
        program_region(FMT_RGBA8888, 8, 4, 1, 2, 3, 2);
        words = '{32'h1122_3344, 32'hFF00_00FF, 32'h00FF_FF00};
        send_words(words);
        program_region(FMT_BGRA8888, 8191, 4096, 4095, 4095, 3, 2);
        words = '{32'hDEAD_BEEF, 32'h0000_0000, 32'hFFFF_FFFF};
        send_words(words);

        program_region(FMT_RGB565, 0, 8191, 4000, 0, 3, 0);
        words = '{32'h1234_5678};
        send_words(words);
        program_region(FMT_RGB565, 8, 2, 0, 0, 3, 2);
        send_words(words);
        program_region(FMT_RGBA8888, 4, 8, 2, 0, 3, 2);
        send_words(words);

        program_region(FMT_BGRA8888, 16, 16, 0, 0, 4, 3);
        words = '{32'h0101_0101, 32'h0202_0202, 32'h0303_0303, 32'h0404_0404,
                  32'h0505_0505};
        send_words(words);
        program_region(FMT_BGRA8888, 16, 16, 0, 0, 1, 1);
        words = '{32'h0606_0606};
        send_words(words);

        program_region(FMT_RGBA8888, 64, 64, 3, 5, 7, 5);
        hold_request = 1'b1;
        stream_pixels(48, 1'b1);
        while (sb.pending() != 0) @(negedge clk);
        stream_pixels(20, 1'b0);

        program_region(FMT_RGB565, 8191, 8191, 17, 4095, 1, 5000);
        stream_pixels(40, 1'b0);
        program_region(FMT_ABGR1555, 8191, 8191, 100, 3000, 6000, 2);
        stream_pixels(40, 1'b0);

        while (random_words < RANDOM_WORDS) begin
            random_phase(sent);
            random_words += sent;
        end

        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
